// ===== rtl/fcbf_pkg.sv =====
`default_nettype none

package fcbf_pkg;

    // Store geometry
    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);

    // Fixed field widths
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 7;
    localparam int MODE_W  = 3;
    localparam int TOTAL_W = 48;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [CNT_W-1:0]   CAP_RESET = CNT_W'(64);

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DROP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_END   = 3'd4;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_PEEK,
        OP_DROP,
        OP_END,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  length;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               out_valid;
        logic               last;
        logic               accepted;
        logic [CNT_W-1:0]   moved_count;
        logic [CNT_W-1:0]   occupancy;
        logic [CNT_W-1:0]   room_left;
        logic               ended;
        logic               at_eof;
        logic [TOTAL_W-1:0] total_written;
        logic [TOTAL_W-1:0] total_read;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/flow_controlled_byte_fifo.sv =====
`default_nettype none

// Byte FIFO with a programmable capacity and full status on every result.
// Input beats carry a command in s_tuser (0 write byte, 1 read, 2 peek,
// 3 drop, 4 end of input, other codes give a plain status beat). A write
// stores its byte only while occupancy is below min(capacity, 64). Read and
// peek return min(length, occupancy) beats, one byte each, with m_tlast on
// the final one; with nothing available they return a single tlast beat
// with m_tuser low. Drop, end and write return one beat. Every result
// beat reports occupancy, room, ended/eof and the two 48-bit saturating
// totals as they stand after that beat. Timing: the front end takes one
// command per cycle, while the queue has room, into a two-entry command
// queue; the back end retires a single-result command straight from
// ST_IDLE. A read or peek takes the command, then for each delivered byte
// passes ST_FETCH (the registered store read) and ST_EMIT (load the
// output register). The output register holds a finished beat until
// m_tready; while it waits the back end can only prefetch the next byte of
// a burst and takes no new command. No clearing pass after reset: the
// store is only read inside the occupied range. The capacity register is
// written on cfg_valid (cfg_ready is always high) and should only change
// while the block is idle.
module flow_controlled_byte_fifo
    import fcbf_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration: capacity_limit
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CNT_W-1:0]   cfg_data,
    // command stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [15:0]        s_tdata,   // [7:0] data_byte, [14:8] length, [15] zero
    input  wire logic [MODE_W-1:0]  s_tuser,   // [2:0] mode
    // result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [127:0]            m_tdata,   // [7:0] out_byte, [8] accepted,
                                               // [15:9] moved_count, [22:16] occupancy,
                                               // [29:23] room_left, [30] ended,
                                               // [31] at_eof, [79:32] total_written,
                                               // [127:80] total_read
    output logic                    m_tuser,   // [0] out_valid
    output logic                    m_tlast    // last beat of the command
);

    logic [CNT_W-1:0]  cap_reg;
    logic              cmd_valid, cmd_ready;
    cmd_t              cmd;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata;
    result_t           res;

    // capacity register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

    // front: decode and queue commands
    fcbf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_mode      (s_tuser),
        .s_data_byte (s_tdata[7:0]),
        .s_length    (s_tdata[14:8]),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd)
    );

    // byte store
    fcbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // back: execute commands, own the queue state and output register
    fcbf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .capacity  (cap_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .result    (res)
    );

    // result packing
    assign m_tdata = {res.total_read, res.total_written, res.at_eof, res.ended,
                      res.room_left, res.occupancy, res.moved_count, res.accepted,
                      res.out_byte};
    assign m_tuser = res.out_valid;
    assign m_tlast = res.last;

    // occupancy never exceeds the store depth
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[22:16] <= CNT_W'(DEPTH)))
        else $error("occupancy above store depth");

    // occupancy plus room never exceeds the store depth
    a_room_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((8'(m_tdata[22:16]) + 8'(m_tdata[29:23])) <= 8'(DEPTH)))
        else $error("room and occupancy inconsistent");

    // an accepted write moves exactly one byte in a single data-less beat
    a_write_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[15:9] == CNT_W'(1) && !m_tuser && m_tlast))
        else $error("malformed write result");

    // eof only when ended and empty
    a_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[31]) |-> (m_tdata[30] && m_tdata[22:16] == '0))
        else $error("eof without ended and empty buffer");

endmodule

`default_nettype wire

// ===== rtl/fcbf_ram.sv =====
`default_nettype none

module fcbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fcbf_front.sv =====
`default_nettype none

module fcbf_front
    import fcbf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [MODE_W-1:0]    s_mode,
    input  wire logic [BYTE_W-1:0]    s_data_byte,
    input  wire logic [CNT_W-1:0]     s_length,
    output logic                      cmd_valid,
    input  wire logic                 cmd_ready,
    output cmd_t                      cmd
);

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;
    cmd_t                  dec;
    logic                  push, pop;

    // mode decode
    always_comb begin
        dec.data   = s_data_byte;
        dec.length = s_length;
        unique case (s_mode)
            MODE_WRITE: dec.op = OP_WRITE;
            MODE_READ:  dec.op = OP_READ;
            MODE_PEEK:  dec.op = OP_PEEK;
            MODE_DROP:  dec.op = OP_DROP;
            MODE_END:   dec.op = OP_END;
            default:    dec.op = OP_NOP;
        endcase
    end

    assign s_tready  = (cnt_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fcbf_back.sv =====
`default_nettype none

module fcbf_back
    import fcbf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [CNT_W-1:0]  capacity,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire cmd_t              cmd,
    output logic                   ram_we,
    output logic [IDX_W-1:0]       ram_waddr,
    output logic [BYTE_W-1:0]      ram_wdata,
    output logic                   ram_re,
    output logic [IDX_W-1:0]       ram_raddr,
    input  wire logic [BYTE_W-1:0] ram_rdata,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output result_t                result
);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                done_reg, done_next;
    logic [TOTAL_W-1:0]  wtot_reg, wtot_next;
    logic [TOTAL_W-1:0]  rtot_reg, rtot_next;
    logic                pop_reg, pop_next;       // burst removes bytes (read, not peek)
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    remain_reg, remain_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic [CNT_W-1:0]    eff_cap;
    logic [CNT_W-1:0]    avail;
    logic                out_free;
    logic                take;
    logic                start_burst;
    logic                emit_ok;

    logic                ld;
    logic [BYTE_W-1:0]   ld_byte;
    logic                ld_valid, ld_last, ld_acc;
    logic [CNT_W-1:0]    ld_moved;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] n);
        logic [IDX_W:0] sum;
        sum = (IDX_W+1)'(base) + (IDX_W+1)'(n);
        if (sum >= (IDX_W+1)'(DEPTH)) begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] v,
                                                   input logic [CNT_W-1:0]   n);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, v} + (TOTAL_W+1)'(n);
        return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    endfunction

    assign eff_cap     = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;
    assign avail       = (cmd.length < fill_reg) ? cmd.length : fill_reg;
    assign out_free    = !out_valid_reg || m_ready;
    assign take        = (state_reg == ST_IDLE) && cmd_valid && out_free;
    assign start_burst = take && (cmd.op == OP_READ || cmd.op == OP_PEEK) && (avail != '0);
    assign emit_ok     = (state_reg == ST_EMIT) && out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_burst) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_EMIT;
            ST_EMIT: begin
                if (emit_ok) begin
                    state_next = (remain_reg == CNT_W'(1)) ? ST_IDLE : ST_FETCH;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        head_next   = head_reg;
        fill_next   = fill_reg;
        done_next   = done_reg;
        wtot_next   = wtot_reg;
        rtot_next   = rtot_reg;
        pop_next    = pop_reg;
        ptr_next    = ptr_reg;
        remain_next = remain_reg;
        count_next  = count_reg;
        cmd_ready   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = wrap_add(head_reg, fill_reg);
        ram_wdata   = cmd.data;
        ram_re      = 1'b0;
        ram_raddr   = ptr_reg;
        ld          = 1'b0;
        ld_byte     = '0;
        ld_valid    = 1'b0;
        ld_last     = 1'b1;
        ld_acc      = 1'b0;
        ld_moved    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = out_free;
                if (take) begin
                    ld = 1'b1;
                    unique case (cmd.op)
                        OP_WRITE: begin
                            if (fill_reg < eff_cap) begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + 1'b1;
                                wtot_next = sat_add(wtot_reg, CNT_W'(1));
                                ld_acc    = 1'b1;
                                ld_moved  = CNT_W'(1);
                            end
                        end
                        OP_READ, OP_PEEK: begin
                            if (avail != '0) begin
                                ld          = 1'b0;
                                pop_next    = (cmd.op == OP_READ);
                                ptr_next    = head_reg;
                                remain_next = avail;
                                count_next  = avail;
                            end
                        end
                        OP_DROP: begin
                            head_next = wrap_add(head_reg, avail);
                            fill_next = fill_reg - avail;
                            rtot_next = sat_add(rtot_reg, avail);
                            ld_moved  = avail;
                        end
                        OP_END: done_next = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_FETCH: begin
                ram_re = 1'b1;
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    ld          = 1'b1;
                    ld_byte     = ram_rdata;
                    ld_valid    = 1'b1;
                    ld_last     = (remain_reg == CNT_W'(1));
                    ld_moved    = count_reg;
                    ptr_next    = wrap_add(ptr_reg, CNT_W'(1));
                    remain_next = remain_reg - 1'b1;
                    if (pop_reg) begin
                        head_next = wrap_add(head_reg, CNT_W'(1));
                        fill_next = fill_reg - 1'b1;
                        rtot_next = sat_add(rtot_reg, CNT_W'(1));
                    end
                end
            end
            default: ;
        endcase

        // result reflects status after this beat
        out_next               = out_reg;
        out_next.out_byte      = ld_byte;
        out_next.out_valid     = ld_valid;
        out_next.last          = ld_last;
        out_next.accepted      = ld_acc;
        out_next.moved_count   = ld_moved;
        out_next.occupancy     = fill_next;
        out_next.room_left     = (eff_cap > fill_next) ? eff_cap - fill_next : '0;
        out_next.ended         = done_next;
        out_next.at_eof        = done_next && (fill_next == '0);
        out_next.total_written = wtot_next;
        out_next.total_read    = rtot_next;
        if (!ld) begin
            out_next = out_reg;
        end
        out_valid_next = ld ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            done_reg      <= 1'b0;
            wtot_reg      <= '0;
            rtot_reg      <= '0;
            out_valid_reg <= 1'b0;
            remain_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            done_reg      <= done_next;
            wtot_reg      <= wtot_next;
            rtot_reg      <= rtot_next;
            out_valid_reg <= out_valid_next;
            remain_reg    <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        pop_reg   <= pop_next;
        ptr_reg   <= ptr_next;
        count_reg <= count_next;
        out_reg   <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign result  = out_reg;

endmodule

`default_nettype wire

// ===== test/flow_controlled_byte_fifo_tb.sv =====
`timescale 1ns / 1ps

module flow_controlled_byte_fifo_tb
    import fcbf_pkg::*;
();

    localparam int          CLK_PERIOD = 8;
    localparam int          SETTLE_CYC = 8;
    localparam int unsigned CYCLE_LIMIT = 900000;
    localparam int          EXP_W      = 10;
    localparam int          EXP_DEPTH  = 1 << EXP_W;

    // ---------------------------------------------------------------
    // DUT signals
    // ---------------------------------------------------------------
    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CNT_W-1:0]   cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [15:0]        s_tdata;   // [7:0] data_byte, [14:8] length, [15] zero
    logic [MODE_W-1:0]  s_tuser;   // [2:0] mode
    logic               m_tvalid;
    logic               m_tready;
    logic [127:0]       m_tdata;   // [7:0] out_byte, [8] accepted, [15:9] moved_count,
                                   // [22:16] occupancy, [29:23] room_left, [30] ended,
                                   // [31] at_eof, [79:32] total_written,
                                   // [127:80] total_read
    logic               m_tuser;   // [0] out_valid
    logic               m_tlast;

    flow_controlled_byte_fifo u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // ---------------------------------------------------------------
    // Bookkeeping
    // ---------------------------------------------------------------
    int unsigned cycle_count  = 0;
    int unsigned error_count  = 0;
    int unsigned cmds_sent    = 0;
    int unsigned beats_seen   = 0;
    int unsigned cap_writes   = 0;
    bit          steady_flow  = 1'b0;  // set for the final part: no gaps, no stalls

    // ---------------------------------------------------------------
    // Shadow FIFO: mirrors the block's state, updated on each accepted
    // command beat, and lists the result beats that command must give
    // ---------------------------------------------------------------
    logic [BYTE_W-1:0]  fifo_mem [DEPTH];
    logic [IDX_W-1:0]   head_now;
    logic [CNT_W-1:0]   fill_now;
    logic               ended_now;
    logic [TOTAL_W-1:0] written_now;
    logic [TOTAL_W-1:0] read_now;
    logic [CNT_W-1:0]   cap_reg;

    // ring of expected beats
    result_t     exp_mem [EXP_DEPTH];
    int unsigned exp_wr = 0;
    int unsigned exp_rd = 0;

    function automatic void queue_beat(input result_t r);
        exp_mem[exp_wr[EXP_W-1:0]] = r;
        exp_wr++;
    endfunction

    function automatic int unsigned beats_pending();
        return exp_wr - exp_rd;
    endfunction

    function automatic logic [CNT_W-1:0] cap_eff();
        return (cap_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_reg;
    endfunction

    function automatic logic [TOTAL_W-1:0] bump_total(input logic [TOTAL_W-1:0] t);
        return (t == TOTAL_MAX) ? t : t + 1'b1;
    endfunction

    // status as it stands right now, plus the per-beat fields
    function automatic result_t status_beat(input logic [BYTE_W-1:0] byte_val,
                                            input logic valid, input logic fin,
                                            input logic acc, input logic [CNT_W-1:0] moved);
        result_t          r;
        logic [CNT_W-1:0] cap;
        cap             = cap_eff();
        r.out_byte      = byte_val;
        r.out_valid     = valid;
        r.last          = fin;
        r.accepted      = acc;
        r.moved_count   = moved;
        r.occupancy     = fill_now;
        r.room_left     = (cap > fill_now) ? cap - fill_now : '0;
        r.ended         = ended_now;
        r.at_eof        = ended_now && (fill_now == 0);
        r.total_written = written_now;
        r.total_read    = read_now;
        return r;
    endfunction

    task automatic model_command(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
                                 input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0]  avail;
        logic [BYTE_W-1:0] byte_now;
        avail = (len < fill_now) ? len : fill_now;
        case (mode)
            MODE_WRITE: begin
                if (fill_now < cap_eff()) begin
                    fifo_mem[IDX_W'(head_now + fill_now)] = data;
                    fill_now    = fill_now + 1'b1;
                    written_now = bump_total(written_now);
                    queue_beat(status_beat('0, 1'b0, 1'b1, 1'b1, CNT_W'(1)));
                end else begin
                    queue_beat(status_beat('0, 1'b0, 1'b1, 1'b0, '0));
                end
            end
            MODE_READ, MODE_PEEK: begin
                if (avail == 0) begin
                    // nothing available: single marked beat, no data
                    queue_beat(status_beat('0, 1'b0, 1'b1, 1'b0, '0));
                end else begin
                    for (int i = 0; i < avail; i++) begin
                        if (mode == MODE_READ) begin
                            // occupancy and read total move with every beat
                            byte_now = fifo_mem[head_now];
                            head_now = head_now + 1'b1;
                            fill_now = fill_now - 1'b1;
                            read_now = bump_total(read_now);
                            queue_beat(status_beat(byte_now, 1'b1, (i + 1 == avail),
                                                   1'b0, avail));
                        end else begin
                            queue_beat(status_beat(
                                fifo_mem[IDX_W'(head_now + i)], 1'b1, (i + 1 == avail),
                                1'b0, avail));
                        end
                    end
                end
            end
            MODE_DROP: begin
                for (int i = 0; i < avail; i++) begin
                    head_now = head_now + 1'b1;
                    fill_now = fill_now - 1'b1;
                    read_now = bump_total(read_now);
                end
                queue_beat(status_beat('0, 1'b0, 1'b1, 1'b0, avail));
            end
            MODE_END: begin
                ended_now = 1'b1;
                queue_beat(status_beat('0, 1'b0, 1'b1, 1'b0, '0));
            end
            default: begin
                // spare codes: status only
                queue_beat(status_beat('0, 1'b0, 1'b1, 1'b0, '0));
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Clock, watchdog
    // ---------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d beats still expected",
                 cycle_count, beats_pending());
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Result side: check every accepted beat and drive m_tready with
    // random stall bursts
    // ---------------------------------------------------------------
    task automatic report_error(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] got,
                               input logic [TOTAL_W-1:0] want);
        if (got !== want)
            report_error($sformatf("beat %0d %s got 0x%0h want 0x%0h",
                                   beats_seen, name, got, want));
    endtask

    task automatic check_beat();
        result_t want;
        if (beats_pending() == 0) begin
            report_error($sformatf("unexpected result beat, m_tdata 0x%0h", m_tdata));
        end else begin
            want = exp_mem[exp_rd[EXP_W-1:0]];
            exp_rd++;
            check_field("out_byte",      TOTAL_W'(m_tdata[7:0]),   TOTAL_W'(want.out_byte));
            check_field("accepted",      TOTAL_W'(m_tdata[8]),     TOTAL_W'(want.accepted));
            check_field("moved_count",   TOTAL_W'(m_tdata[15:9]),
                        TOTAL_W'(want.moved_count));
            check_field("occupancy",     TOTAL_W'(m_tdata[22:16]), TOTAL_W'(want.occupancy));
            check_field("room_left",     TOTAL_W'(m_tdata[29:23]), TOTAL_W'(want.room_left));
            check_field("ended",         TOTAL_W'(m_tdata[30]),    TOTAL_W'(want.ended));
            check_field("at_eof",        TOTAL_W'(m_tdata[31]),    TOTAL_W'(want.at_eof));
            check_field("total_written", m_tdata[79:32],  want.total_written);
            check_field("total_read",    m_tdata[127:80], want.total_read);
            check_field("out_valid",     TOTAL_W'(m_tuser),        TOTAL_W'(want.out_valid));
            check_field("last",          TOTAL_W'(m_tlast),        TOTAL_W'(want.last));
        end
        beats_seen++;
    endtask

    int unsigned stall_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_beat();
            if (stall_left > 0 && !steady_flow) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Command side
    // ---------------------------------------------------------------
    // one command beat; tvalid stays high afterwards unless a gap follows
    task automatic push_command(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
                                input logic [CNT_W-1:0] len);
        if (!steady_flow && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, len, data};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model_command(mode, data, len);
        cmds_sent++;
    endtask

    // stop sending and let every expected beat come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (beats_pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // capacity register write, only with the block idle
    task automatic set_capacity(input logic [CNT_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cap_reg = value;
        cap_writes++;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // data extremes, every mode, the nothing-available beats, spare codes
    task automatic test_basic_modes();
        set_capacity(CNT_W'(64));
        push_command(MODE_WRITE, 8'h00, '0);
        push_command(MODE_WRITE, 8'hFF, 7'h7F);
        push_command(MODE_WRITE, 8'hA5, '0);
        push_command(MODE_PEEK,  8'h00, 7'd2);
        push_command(MODE_READ,  8'hFF, 7'd0);   // zero length: marked empty beat
        push_command(MODE_READ,  8'h00, 7'h7F);  // asks more than held
        push_command(MODE_READ,  8'h00, 7'd1);   // empty buffer
        push_command(MODE_PEEK,  8'h00, 7'd1);
        push_command(MODE_DROP,  8'h00, 7'd1);
        for (int m = MODE_END + 1; m < (1 << MODE_W); m++)
            push_command(MODE_W'(m), 8'h5A, 7'd3);
    endtask

    // full buffer, capacity lowered under occupancy, zero and above-depth
    task automatic test_capacity_limits();
        set_capacity(CNT_W'(2));
        push_command(MODE_WRITE, 8'h11, '0);
        push_command(MODE_WRITE, 8'h22, '0);
        push_command(MODE_WRITE, 8'h33, '0);     // refused, buffer full
        set_capacity(CNT_W'(1));                 // now below occupancy
        push_command(MODE_WRITE, 8'h44, '0);
        push_command(MODE_DROP,  8'h00, 7'd64);
        set_capacity(CNT_W'(0));
        push_command(MODE_WRITE, 8'h55, '0);
        set_capacity(7'h7F);                     // clipped to the store depth
        push_command(MODE_WRITE, 8'h66, '0);
    endtask

    // end flag, repeated end, write after end, eof once drained
    task automatic test_end_of_input();
        push_command(MODE_END,   8'h00, '0);
        push_command(MODE_END,   8'hFF, 7'h7F);
        push_command(MODE_WRITE, 8'h77, '0);
        push_command(MODE_READ,  8'h00, 7'd5);
    endtask

    // mostly write bursts followed by reads, with some peeks, drops and noise
    task automatic test_random_traffic(input int unsigned n_cmds);
        int unsigned sent;
        int unsigned pick;
        int unsigned burst;
        logic [CNT_W-1:0] len;
        sent = 0;
        while (sent < n_cmds) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 5) == 0)
                len = CNT_W'($urandom_range(0, 127));
            else
                len = CNT_W'($urandom_range(1, 12));
            if (pick < 45) begin
                burst = $urandom_range(1, 12);
                if (burst > n_cmds - sent)
                    burst = n_cmds - sent;
                repeat (burst) push_command(MODE_WRITE, 8'($urandom), CNT_W'($urandom));
                sent += burst;
            end else begin
                if (pick < 70)
                    push_command(MODE_READ, 8'($urandom), len);
                else if (pick < 80)
                    push_command(MODE_PEEK, 8'($urandom), len);
                else if (pick < 90)
                    push_command(MODE_DROP, 8'($urandom), len);
                else if (pick < 95)
                    push_command(MODE_END, 8'($urandom), CNT_W'($urandom));
                else
                    push_command(MODE_W'($urandom_range(MODE_END + 1, (1 << MODE_W) - 1)),
                                 8'($urandom), CNT_W'($urandom));
                sent++;
            end
        end
    endtask

    // back to back at full depth: fill past the top, then a full peek and one long read
    task automatic test_full_depth_stream();
        set_capacity(7'h7F);
        steady_flow = 1'b1;
        repeat (DEPTH + 2) push_command(MODE_WRITE, 8'($urandom), '0);
        push_command(MODE_PEEK, 8'h00, CNT_W'(DEPTH));
        push_command(MODE_READ, 8'h00, 7'h7F);
        push_command(MODE_WRITE, 8'($urandom), '0);
        push_command(MODE_READ, 8'h00, 7'd1);
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;

        head_now    = '0;
        fill_now    = '0;
        ended_now   = 1'b0;
        written_now = '0;
        read_now    = '0;
        cap_reg     = CAP_RESET;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_modes();
        test_capacity_limits();
        test_end_of_input();

        set_capacity(CNT_W'(64));
        test_random_traffic(8);
        set_capacity(CNT_W'(7));
        test_random_traffic(7);
        set_capacity(CNT_W'($urandom_range(0, 127)));
        test_random_traffic(6);
        set_capacity(CNT_W'(40));
        test_random_traffic(6);

        test_full_depth_stream();

        wait_drained();
        if (beats_pending() != 0)
            report_error($sformatf("%0d beats never arrived", beats_pending()));

        $display("Sent %0d commands (all modes, spare codes) over %0d capacity writes",
                 cmds_sent, cap_writes);
        $display("Checked %0d result beats field by field, %0d mismatches",
                 beats_seen, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
